/* sv/itd_pkg.sv */
// Shared constants, types and the digit-to-ASCII mapping for the integer to ASCII converter.
package itd_pkg;

  localparam int VALUE_BITS = 32;
  localparam int IN_VALUE_W = 32;
  localparam int CHAR_W     = 8;
  localparam int TOTAL_W    = 31;

  localparam int DEC_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
  localparam int NDIG       = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
  localparam int IDX_W      = $clog2(NDIG);
  localparam int CNT_W      = $clog2(VALUE_BITS);

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;

  typedef enum logic [1:0] {
    OP_SDEC = 2'd0,
    OP_UDEC = 2'd1,
    OP_LHEX = 2'd2,
    OP_UHEX = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_CONV = 2'd1,
    ST_EMIT = 2'd2
  } top_state_e;

  typedef enum logic [1:0] {
    CV_IDLE  = 2'd0,
    CV_SHIFT = 2'd1,
    CV_FIND  = 2'd2
  } conv_state_e;

  typedef struct packed {
    logic [1:0]            op;
    logic [IN_VALUE_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic [CHAR_W-1:0]  ascii_char;
    logic               last;
    logic [TOTAL_W-1:0] total_chars;
  } out_t;

  typedef struct packed {
    logic                  start;
    logic                  hex;
    logic [VALUE_BITS-1:0] mag;
  } conv_req_t;

  typedef struct packed {
    logic                       done;
    logic [IDX_W-1:0]           msd;
    logic [NDIG-1:0][3:0]       digits;
  } conv_rsp_t;

  function automatic logic [CHAR_W-1:0] ascii_of(input logic [3:0] nib, input logic upper);
    logic [CHAR_W-1:0] base;
    base = upper ? CH_UA : CH_LA;
    if (nib < 4'd10) begin
      return CH_ZERO + {4'd0, nib};
    end
    return base + {4'd0, nib} - 8'd10;
  endfunction

endpackage

/* sv/itd_conv.sv */
// Iterative shift-and-add-3 binary to BCD unit with hex bypass and leading digit search.
module itd_conv import itd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  conv_req_t req_i,
  output conv_rsp_t rsp_o
);

  conv_state_e           state_q, state_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [NDIG-1:0][3:0]  bcd_q, bcd_d;
  logic [VALUE_BITS-1:0] bin_q, bin_d;
  logic [NDIG-1:0][3:0]  bcd_fix;
  logic [IDX_W-1:0]      msd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CV_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bcd_q <= bcd_d;
    bin_q <= bin_d;
  end

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      bcd_fix[i] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
    end
  end

  always_comb begin
    msd = '0;
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_q[i] != 4'd0) begin
        msd = IDX_W'(i);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    bcd_d   = bcd_q;
    bin_d   = bin_q;
    case (state_q)
      CV_IDLE: begin
        if (req_i.start) begin
          cnt_d = '0;
          if (req_i.hex) begin
            bcd_d   = (NDIG*4)'(req_i.mag);
            state_d = CV_FIND;
          end else begin
            bcd_d   = '0;
            bin_d   = req_i.mag;
            state_d = CV_SHIFT;
          end
        end
      end
      CV_SHIFT: begin
        bcd_d = (NDIG*4)'({bcd_fix, bin_q[VALUE_BITS-1]});
        bin_d = bin_q << 1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(VALUE_BITS - 1)) begin
          state_d = CV_FIND;
        end
      end
      CV_FIND: begin
        state_d = CV_IDLE;
      end
      default: begin
        state_d = CV_IDLE;
      end
    endcase
  end

  assign rsp_o.done   = (state_q == CV_FIND);
  assign rsp_o.msd    = msd;
  assign rsp_o.digits = bcd_q;

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.done |=> !rsp_o.done)
    else $error("conversion done held longer than one cycle");

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.start && state_q == CV_IDLE && !req_i.hex) |=> state_q == CV_SHIFT && cnt_q == '0)
    else $error("decimal conversion did not start shifting");

  a_shift_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == CV_SHIFT && cnt_q == CNT_W'(VALUE_BITS - 1)) |=> state_q == CV_FIND)
    else $error("shift phase did not end after the last bit");

endmodule

/* sv/integer_to_ascii_digits_top.sv */
// Integer to ASCII digit converter: handshake, sequencing, character output and running count.
// Decimal: a minus sign is issued first, once the output slot is free; the first digit follows
//   the BCD shift phase over all input bits, the leading digit search and the index load.
// Hex: the first digit follows the leading digit search and the index load. Then one character
//   per cycle while the output does not stall. Input stalls until the last character is issued.
//   Reset clears sequencer, valid, count.
module integer_to_ascii_digits_top import itd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  top_state_e            state_q, state_d;
  logic                  sign_q, sign_d;
  logic                  upper_q, upper_d;
  logic [IDX_W-1:0]      idx_q, idx_d;
  logic                  out_valid_q, out_valid_d;
  out_t                  out_q;
  logic [TOTAL_W-1:0]    tot_q, tot_next;
  logic                  slot_free;
  logic                  ld;
  logic [CHAR_W-1:0]     ld_char;
  logic                  ld_last;
  logic [VALUE_BITS-1:0] val;
  logic                  neg;
  conv_req_t             conv_req;
  conv_rsp_t             conv_rsp;

  assign val = VALUE_BITS'(in_data_i.value);
  assign neg = (in_data_i.op == OP_SDEC) && val[VALUE_BITS-1];

  assign conv_req.start = (state_q == ST_IDLE) && in_valid_i;
  assign conv_req.hex   = in_data_i.op[1];
  assign conv_req.mag   = neg ? (~val + 1'b1) : val;

  itd_conv u_conv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (conv_req),
    .rsp_o  (conv_rsp)
  );

  assign slot_free = !out_valid_q || !out_stall_i;
  assign tot_next  = (tot_q == TOTAL_MAX) ? tot_q : tot_q + 1'b1;

  always_comb begin
    state_d = state_q;
    sign_d  = sign_q;
    upper_d = upper_q;
    idx_d   = idx_q;
    ld      = 1'b0;
    ld_char = CH_MINUS;
    ld_last = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          sign_d  = neg;
          upper_d = (in_data_i.op == OP_UHEX);
          state_d = ST_CONV;
        end
      end
      ST_CONV: begin
        if (sign_q && slot_free) begin
          ld     = 1'b1;
          sign_d = 1'b0;
        end
        if (conv_rsp.done) begin
          idx_d   = conv_rsp.msd;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          ld = 1'b1;
          if (sign_q) begin
            sign_d = 1'b0;
          end else begin
            ld_char = ascii_of(conv_rsp.digits[idx_q], upper_q);
            ld_last = (idx_q == '0);
            if (idx_q == '0) begin
              state_d = ST_IDLE;
            end else begin
              idx_d = idx_q - 1'b1;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (ld) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sign_q      <= 1'b0;
      out_valid_q <= 1'b0;
      tot_q       <= '0;
    end else begin
      state_q     <= state_d;
      sign_q      <= sign_d;
      out_valid_q <= out_valid_d;
      if (ld) begin
        tot_q <= tot_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    upper_q <= upper_d;
    idx_q   <= idx_d;
    if (ld) begin
      out_q.ascii_char  <= ld_char;
      out_q.last        <= ld_last;
      out_q.total_chars <= tot_next;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_sign_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sign_q |-> state_q != ST_IDLE)
    else $error("minus sign pending while idle");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ld && ld_last) |=> state_q == ST_IDLE && out_valid_o && out_data_o.last)
    else $error("last character did not end the number");

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.total_chars != '0)
    else $error("character count zero on a valid word");

  a_sign_before_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ld && sign_q) |-> ld_char == CH_MINUS && !ld_last)
    else $error("minus sign not issued first");

endmodule
